>>> sv/wacal_pkg.sv
// Package for the windowed average / quadratic calibration block.
// Sizes, register index codes and fixed constants; no dependencies.
package wacal_pkg;

   localparam int RING_DEPTH        = 30;
   localparam int SAMPLES_PER_LEVEL = 3;

   localparam int SAMPLE_W = 24;
   localparam int LEVEL_W  = 4;
   localparam int COEF_W   = 32;
   localparam int READ_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > 6) ? FILL_W : 6;
   localparam int SUM_W  = SAMPLE_W + FILL_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 57;

   // 999.99 degree in 1/256 degree
   localparam logic [SAMPLE_W-1:0] NO_DATA_VALUE = SAMPLE_W'(255997);

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_COEF  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_COEF  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_COEF  = 2'd3;

   localparam logic [COEF_W-1:0] LINEAR_RESET = COEF_W'(65536);

endpackage

>>> sv/wacal_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wacal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/windowed_average_quadratic_calibration_top.sv
// Top level: sample ring, window sum, serial divider and shared multiplier
// running the calibration a + b*x + c*x*x. Uses wacal_pkg and wacal_ram.
//
//   channel | signals                                     | direction
//   req     | req_valid/ready, req_mode, req_sample_value | in
//   rsp     | rsp_valid/ready, rsp_reading, rsp_no_data,  | out
//           | rsp_saturated                               |
//   csr     | csr_wr_en, csr_index, csr_wr_data           | in
//
// A read request makes one ring read per cycle over the window, then one
// quotient bit per cycle in the divider, then four passes of the multiplier.
// With no sample stored a read skips the sum and the divider and goes straight
// to the multiplier passes. No clearing pass after reset.
// The result sits in an output register, so req is ready again while it waits;
// a second read then holds at its final step, req not ready, until rsp is taken.
module windowed_average_quadratic_calibration_top
   import wacal_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic signed [SAMPLE_W-1:0]  req_sample_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [READ_W-1:0]    rsp_reading,
   output logic                        rsp_no_data,
   output logic                        rsp_saturated,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COEF_W-1:0]           csr_wr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SUM  = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_CAL0 = 4'd3;
   localparam logic [3:0] S_CAL1 = 4'd4;
   localparam logic [3:0] S_CAL2 = 4'd5;
   localparam logic [3:0] S_CAL3 = 4'd6;
   localparam logic [3:0] S_CAL4 = 4'd7;
   localparam logic [3:0] S_CAL5 = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   // configuration
   logic [LEVEL_W-1:0] level_ff;
   logic [COEF_W-1:0]  offset_ff, linear_ff, square_ff;

   // control
   logic [3:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              wrapped_ff, wrapped_in;
   logic [FILL_W-1:0] left_ff, left_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [FILL_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [SAMPLE_W-1:0]     xmag_ff, xmag_in;
   logic                    xneg_ff, xneg_in;
   logic                    nd_ff, nd_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [PROD_W-1:0]       sq_ff, sq_in;
   logic [SAMPLE_W-1:0]     lo_ff, lo_in;
   logic signed [READ_W-1:0] rd_out_ff, rd_out_in;
   logic                    nd_out_ff, nd_out_in;
   logic                    sat_out_ff, sat_out_in;

   // ring
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   // helpers
   logic [MUL_W-1:0]    op_a, op_b;
   logic [COEF_W-1:0]   bmag, cmag;
   logic                bneg, cneg;
   logic signed [ACC_W-1:0] a_term;
   logic [CMP_W-1:0]    win_raw, win_cap;
   logic [FILL_W-1:0]   win_cnt;
   logic [SUM_W-1:0]    sum_lo, sum_mag;
   logic [FILL_W:0]     shifted;
   logic                qbit;
   logic                sat_hi, sat_lo;

   wacal_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reading   = rd_out_ff;
   assign rsp_no_data   = nd_out_ff;
   assign rsp_saturated = sat_out_ff;

   assign wr_en   = req_valid && req_ready && !req_mode;
   assign wr_addr = (fill_ff >= FILL_W'(RING_DEPTH)) ? '0 : fill_ff[ADDR_W-1:0];

   assign bneg = linear_ff[COEF_W-1];
   assign cneg = square_ff[COEF_W-1];
   assign bmag = bneg ? (~linear_ff + COEF_W'(1)) : linear_ff;
   assign cmag = cneg ? (~square_ff + COEF_W'(1)) : square_ff;

   // offset / 256, truncated toward zero
   always_comb begin
      a_term = ACC_W'($signed(offset_ff) >>> 8);
      if (offset_ff[COEF_W-1] && (offset_ff[7:0] != 8'd0)) begin
         a_term = a_term + ACC_W'(1);
      end
   end

   // window length for the current level
   always_comb begin
      win_raw = CMP_W'(level_ff) * CMP_W'(SAMPLES_PER_LEVEL);
      win_cap = (win_raw > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH) : win_raw;
      win_cnt = win_cap[FILL_W-1:0];
      if (level_ff == '0) begin
         win_cnt = FILL_W'(1);
      end else if (!wrapped_ff && (win_cnt > fill_ff)) begin
         win_cnt = fill_ff;
      end
   end

   assign sum_lo  = acc_ff[SUM_W-1:0];
   assign sum_mag = sum_lo[SUM_W-1] ? (~sum_lo + SUM_W'(1)) : sum_lo;
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign qbit    = (shifted >= {1'b0, cnt_ff});

   assign sat_hi = !acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:READ_W-1] != '0);
   assign sat_lo = acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:READ_W-1] != '1);

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_CAL0: begin
            op_a = bmag;
            op_b = MUL_W'(xmag_ff);
         end
         S_CAL1: begin
            op_a = MUL_W'(xmag_ff);
            op_b = MUL_W'(xmag_ff);
         end
         S_CAL2: begin
            op_a = cmag;
            op_b = MUL_W'(prod_ff[2*SAMPLE_W-1:24]);
         end
         S_CAL3: begin
            op_a = cmag;
            op_b = MUL_W'(lo_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      wrapped_in   = wrapped_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      xmag_in      = xmag_ff;
      xneg_in      = xneg_ff;
      nd_in        = nd_ff;
      prod_in      = PROD_W'(op_a) * PROD_W'(op_b);
      sq_in        = sq_ff;
      lo_in        = lo_ff;
      rd_out_in    = rd_out_ff;
      nd_out_in    = nd_out_ff;
      sat_out_in   = sat_out_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_mode) begin
                  fill_in = FILL_W'(wr_addr) + FILL_W'(1);
                  if (fill_ff >= FILL_W'(RING_DEPTH)) begin
                     wrapped_in = 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  xmag_in  = NO_DATA_VALUE;
                  xneg_in  = 1'b0;
                  nd_in    = 1'b1;
                  state_in = S_CAL0;
               end else begin
                  nd_in    = 1'b0;
                  acc_in   = '0;
                  cnt_in   = win_cnt;
                  left_in  = win_cnt;
                  ptr_in   = ADDR_W'(fill_ff - FILL_W'(1));
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (left_ff != '0) begin
               left_in = left_ff - FILL_W'(1);
               pend_in = 1'b1;
               ptr_in  = (ptr_ff == '0) ? ADDR_W'(RING_DEPTH - 1) : ptr_ff - ADDR_W'(1);
            end
            if (pend_ff) begin
               acc_in = acc_ff + {{(ACC_W-SAMPLE_W){ram_rd_data[SAMPLE_W-1]}}, ram_rd_data};
            end
            if ((left_ff == '0) && !pend_ff) begin
               xneg_in  = sum_lo[SUM_W-1];
               quo_in   = sum_mag;
               rem_in   = '0;
               dcnt_in  = DCNT_W'(SUM_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = qbit ? FILL_W'(shifted - {1'b0, cnt_ff}) : shifted[FILL_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], qbit};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               xmag_in  = quo_in[SAMPLE_W-1:0];
               state_in = S_CAL0;
            end
         end
         S_CAL0: begin
            acc_in   = a_term;
            state_in = S_CAL1;
         end
         S_CAL1: begin
            if (bneg ^ xneg_ff) begin
               acc_in = acc_ff - ACC_W'(prod_ff[PROD_W-1:16]);
            end else begin
               acc_in = acc_ff + ACC_W'(prod_ff[PROD_W-1:16]);
            end
            state_in = S_CAL2;
         end
         S_CAL2: begin
            lo_in    = prod_ff[SAMPLE_W-1:0];
            state_in = S_CAL3;
         end
         S_CAL3: begin
            sq_in    = prod_ff;
            state_in = S_CAL4;
         end
         S_CAL4: begin
            sq_in    = sq_ff + (prod_ff >> 24);
            state_in = S_CAL5;
         end
         S_CAL5: begin
            if (cneg) begin
               acc_in = acc_ff - ACC_W'(sq_ff);
            end else begin
               acc_in = acc_ff + ACC_W'(sq_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               nd_out_in    = nd_ff;
               sat_out_in   = sat_hi || sat_lo;
               if (sat_hi) begin
                  rd_out_in = {1'b0, {(READ_W-1){1'b1}}};
               end else if (sat_lo) begin
                  rd_out_in = {1'b1, {(READ_W-1){1'b0}}};
               end else begin
                  rd_out_in = acc_ff[READ_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         wrapped_ff   <= 1'b0;
         left_ff      <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         offset_ff    <= '0;
         linear_ff    <= LINEAR_RESET;
         square_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wrapped_ff   <= wrapped_in;
         left_ff      <= left_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_WINDOW_LEVEL: level_ff  <= csr_wr_data[LEVEL_W-1:0];
               REG_OFFSET_COEF:  offset_ff <= csr_wr_data;
               REG_LINEAR_COEF:  linear_ff <= csr_wr_data;
               REG_SQUARE_COEF:  square_ff <= csr_wr_data;
               default:          level_ff  <= level_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      xmag_ff    <= xmag_in;
      xneg_ff    <= xneg_in;
      nd_ff      <= nd_in;
      prod_ff    <= prod_in;
      sq_ff      <= sq_in;
      lo_ff      <= lo_in;
      rd_out_ff  <= rd_out_in;
      nd_out_ff  <= nd_out_in;
      sat_out_ff <= sat_out_in;
   end

endmodule
